FILE: hdl/pts_pkg.sv
// Package for the polar trajectory statistics block.
// Holds the item and handshake types, state encodings, field widths and the
// CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps

package pts_pkg;

  localparam int RADIUS_W       = 32;
  localparam int ANGLE_W        = 32;
  localparam int SUM_W          = 56;
  localparam int SWEEP_W        = 48;
  localparam int COUNT_OUT_W    = 24;
  localparam int COUNT_MAX_BITS = 32;
  localparam int SQRT_IN_W      = 2 * RADIUS_W;
  localparam int REM_W          = RADIUS_W + 2;
  localparam int STEP_W         = 5;
  localparam int CORDIC_STEPS   = 32;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COUNT_BITS_DEF  = 24;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_CART  = 2'd0;
  localparam logic [1:0] OP_POLAR = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic signed [SUM_W-1:0] ANGLE_SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ANGLE_SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};
  localparam logic signed [SWEEP_W-1:0] SWEEP_MAX = {1'b0, {(SWEEP_W - 1){1'b1}}};
  localparam logic signed [SWEEP_W-1:0] SWEEP_MIN = {1'b1, {(SWEEP_W - 1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_POS_MAX = {1'b0, {(ANGLE_W - 1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_NEG_MAX = {1'b1, {(ANGLE_W - 1){1'b0}}};
  localparam logic [ANGLE_W-1:0] HALF_TURN = {1'b1, {(ANGLE_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_CART,
    KIND_POLAR,
    KIND_CLEAR,
    KIND_NOP
  } item_kind_e;

  typedef struct packed {
    item_kind_e                 kind;
    logic signed [31:0]         x_pos;
    logic signed [31:0]         y_pos;
    logic [RADIUS_W-1:0]        radius;
    logic signed [ANGLE_W-1:0]  angle;
  } item_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
  } polar_req_t;

  typedef struct packed {
    logic                      done;
    logic [RADIUS_W-1:0]       radius;
    logic signed [ANGLE_W-1:0] angle;
  } polar_rsp_t;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_SQX,
    PS_SQY,
    PS_ITER,
    PS_DONE
  } polar_state_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_WAIT,
    BS_APPLY
  } back_state_e;

  // Rounded atan(2^-i) in binary angle units, one turn being 2^32.
  function automatic logic [ANGLE_W-1:0] cordic_atan(input logic [STEP_W-1:0] idx);
    logic [ANGLE_W-1:0] val;
    case (idx)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      5'd24: val = 32'd41;
      5'd25: val = 32'd20;
      5'd26: val = 32'd10;
      5'd27: val = 32'd5;
      5'd28: val = 32'd3;
      5'd29: val = 32'd1;
      5'd30: val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: hdl/pts_front.sv
// Front end of the trajectory statistics block: accepts input transfers,
// classifies the opcode and trims coordinates to the configured width.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_front #(
  parameter int COORD_WIDTH = pts_pkg::COORD_WIDTH_DEF
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] x_pos_i,
  input  logic signed [31:0] y_pos_i,
  input  logic [31:0]        radius_in_i,
  input  logic signed [31:0] angle_in_i,
  output logic               item_valid_o,
  output pts_pkg::item_t     item_o,
  input  logic               item_stall_i
);
  import pts_pkg::*;

  localparam int CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

  logic signed [CW-1:0] x_cw;
  logic signed [CW-1:0] y_cw;

  assign x_cw = x_pos_i[CW-1:0];
  assign y_cw = y_pos_i[CW-1:0];

  always_comb begin
    case (opcode_i)
      OP_CART:  item_o.kind = KIND_CART;
      OP_POLAR: item_o.kind = KIND_POLAR;
      OP_CLEAR: item_o.kind = KIND_CLEAR;
      default:  item_o.kind = KIND_NOP;
    endcase
    item_o.x_pos  = 32'(x_cw);
    item_o.y_pos  = 32'(y_cw);
    item_o.radius = radius_in_i;
    item_o.angle  = angle_in_i;
  end

  assign item_valid_o = in_valid_i;
  assign in_stall_o   = item_stall_i;

endmodule

FILE: hdl/pts_queue.sv
// Short queue between the front end and the back end of the statistics block.
// Holds classified items so that each side stalls on its own. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  pts_pkg::item_t push_item_i,
  output logic           push_stall_o,
  output logic           pop_valid_o,
  output pts_pkg::item_t pop_item_o,
  input  logic           pop_stall_i
);
  import pts_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push;
  logic              pop;

  assign push_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && !push_stall_o;
  assign pop  = pop_valid_o && !pop_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/pts_polar.sv
// Cartesian to polar conversion unit: squares the coordinates on one shared
// multiplier, then runs a digit-by-digit square root and a CORDIC vectoring
// rotation side by side, one step per cycle. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_polar #(
  parameter int COORD_WIDTH = pts_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pts_pkg::polar_req_t req_i,
  output pts_pkg::polar_rsp_t rsp_o
);
  import pts_pkg::*;

  localparam int CW   = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam int W    = CW + 4;
  localparam int SQ_W = 2 * CW;

  polar_state_e state_q;
  polar_state_e state_d;

  logic signed [CW-1:0] x_cw;
  logic signed [CW-1:0] y_cw;
  logic                 x_neg;
  logic                 y_neg;
  logic signed [W-1:0]  x_w;
  logic signed [W-1:0]  y_w;
  logic [CW-1:0]        ax;
  logic [CW-1:0]        ay;

  logic [CW-1:0]        ax_q;
  logic [CW-1:0]        ay_q;
  logic [CW-1:0]        mul_op;
  logic [SQ_W-1:0]      mul_res;
  logic [SQ_W-1:0]      prod_q;

  logic signed [W-1:0]  cx_q;
  logic signed [W-1:0]  cy_q;
  logic [ANGLE_W-1:0]   z_q;
  logic                 zero_q;
  logic signed [W-1:0]  xs;
  logic signed [W-1:0]  ys;
  logic signed [W-1:0]  cx_n;
  logic signed [W-1:0]  cy_n;
  logic [ANGLE_W-1:0]   z_n;

  logic [SQRT_IN_W-1:0] v_q;
  logic [RADIUS_W-1:0]  root_q;
  logic [REM_W-1:0]     rem_q;
  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;
  logic [REM_W-1:0]     rem_n;
  logic [RADIUS_W-1:0]  root_n;

  logic [STEP_W-1:0]    step_q;

  assign x_cw  = req_i.x_pos[CW-1:0];
  assign y_cw  = req_i.y_pos[CW-1:0];
  assign x_neg = x_cw[CW-1];
  assign y_neg = y_cw[CW-1];
  assign x_w   = W'(x_cw);
  assign y_w   = W'(y_cw);
  assign ax    = x_neg ? CW'(-x_cw) : CW'(x_cw);
  assign ay    = y_neg ? CW'(-y_cw) : CW'(y_cw);

  assign mul_op  = (state_q == PS_SQX) ? ax_q : ay_q;
  assign mul_res = SQ_W'(mul_op) * SQ_W'(mul_op);

  always_comb begin
    xs = cx_q >>> step_q;
    ys = cy_q >>> step_q;
    if (!cy_q[W-1]) begin
      cx_n = cx_q + ys;
      cy_n = cy_q - xs;
      z_n  = z_q + cordic_atan(step_q);
    end else begin
      cx_n = cx_q - ys;
      cy_n = cy_q + xs;
      z_n  = z_q - cordic_atan(step_q);
    end
  end

  always_comb begin
    rem_sh = {rem_q, v_q[SQRT_IN_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_n  = REM_W'(rem_sh - trial);
      root_n = {root_q[RADIUS_W-2:0], 1'b1};
    end else begin
      rem_n  = rem_sh[REM_W-1:0];
      root_n = {root_q[RADIUS_W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      PS_IDLE: begin
        if (req_i.start) begin
          state_d = PS_SQX;
        end
      end
      PS_SQX: state_d = PS_SQY;
      PS_SQY: state_d = PS_ITER;
      PS_ITER: begin
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = PS_DONE;
        end
      end
      PS_DONE: state_d = PS_IDLE;
      default: state_d = PS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == PS_ITER) begin
        step_q <= step_q + STEP_W'(1);
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      PS_IDLE: begin
        if (req_i.start) begin
          ax_q   <= ax;
          ay_q   <= ay;
          zero_q <= (x_cw == '0) && (y_cw == '0);
          cx_q   <= x_neg ? -x_w : x_w;
          cy_q   <= x_neg ? -y_w : y_w;
          z_q    <= x_neg ? HALF_TURN : '0;
        end
      end
      PS_SQX: prod_q <= mul_res;
      PS_SQY: begin
        v_q    <= SQRT_IN_W'(prod_q + mul_res);
        root_q <= '0;
        rem_q  <= '0;
      end
      PS_ITER: begin
        cx_q   <= cx_n;
        cy_q   <= cy_n;
        z_q    <= z_n;
        v_q    <= {v_q[SQRT_IN_W-3:0], 2'b00};
        root_q <= root_n;
        rem_q  <= rem_n;
      end
      default: ;
    endcase
  end

  assign rsp_o.done   = (state_q == PS_DONE);
  assign rsp_o.radius = root_q;
  assign rsp_o.angle  = zero_q ? '0 : z_q;

endmodule

FILE: hdl/pts_back.sv
// Back end of the trajectory statistics block: takes items from the queue,
// runs cartesian samples through the conversion unit and updates the running
// statistics, which also serve as the output register. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_back #(
  parameter int COUNT_BITS = pts_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  pts_pkg::item_t      q_item_i,
  output logic                q_stall_o,
  output pts_pkg::polar_req_t polar_req_o,
  input  pts_pkg::polar_rsp_t polar_rsp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         radius_min_o,
  output logic [31:0]         radius_max_o,
  output logic [55:0]         radius_sum_o,
  output logic signed [31:0]  angle_min_o,
  output logic signed [31:0]  angle_max_o,
  output logic signed [55:0]  angle_sum_o,
  output logic signed [47:0]  swept_angle_o,
  output logic [23:0]         sample_count_o
);
  import pts_pkg::*;

  back_state_e state_q;
  back_state_e state_d;
  logic        apply;
  logic        out_valid_q;
  logic        out_valid_d;

  item_kind_e                kind_q;
  logic [RADIUS_W-1:0]       smp_r_q;
  logic signed [ANGLE_W-1:0] smp_a_q;

  logic [RADIUS_W-1:0]       rmin_q, rmin_d;
  logic [RADIUS_W-1:0]       rmax_q, rmax_d;
  logic [SUM_W-1:0]          rsum_q, rsum_d;
  logic signed [ANGLE_W-1:0] amin_q, amin_d;
  logic signed [ANGLE_W-1:0] amax_q, amax_d;
  logic signed [SUM_W-1:0]   asum_q, asum_d;
  logic signed [SWEEP_W-1:0] sweep_q, sweep_d;
  logic signed [ANGLE_W-1:0] prev_q, prev_d;
  logic [COUNT_BITS-1:0]     cnt_q, cnt_d;

  logic [SUM_W:0]            rsum_ext;
  logic signed [SUM_W:0]     asum_ext;
  logic signed [ANGLE_W-1:0] step;
  logic signed [SWEEP_W:0]   sweep_ext;
  logic [SUM_W-1:0]          rsum_sat;
  logic signed [SUM_W-1:0]   asum_sat;
  logic signed [SWEEP_W-1:0] sweep_sat;
  logic [COUNT_MAX_BITS-1:0] cnt_wide;

  always_comb begin
    state_d           = state_q;
    q_stall_o         = 1'b1;
    apply             = 1'b0;
    polar_req_o.start = 1'b0;
    polar_req_o.x_pos = q_item_i.x_pos;
    polar_req_o.y_pos = q_item_i.y_pos;
    case (state_q)
      BS_IDLE: begin
        q_stall_o = 1'b0;
        if (q_valid_i) begin
          if (q_item_i.kind == KIND_CART) begin
            polar_req_o.start = 1'b1;
            state_d           = BS_WAIT;
          end else begin
            state_d = BS_APPLY;
          end
        end
      end
      BS_WAIT: begin
        if (polar_rsp_i.done) begin
          state_d = BS_APPLY;
        end
      end
      BS_APPLY: begin
        if (!out_valid_q || !out_stall_i) begin
          apply   = 1'b1;
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  assign out_valid_d = apply || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (state_q == BS_IDLE && q_valid_i) begin
      kind_q  <= q_item_i.kind;
      smp_r_q <= q_item_i.radius;
      smp_a_q <= q_item_i.angle;
    end else if (state_q == BS_WAIT && polar_rsp_i.done) begin
      smp_r_q <= polar_rsp_i.radius;
      smp_a_q <= polar_rsp_i.angle;
    end
  end

  // Saturating accumulators: one guard bit flags overflow past the limits.
  always_comb begin
    rsum_ext  = (SUM_W + 1)'(rsum_q) + (SUM_W + 1)'(smp_r_q);
    asum_ext  = (SUM_W + 1)'(asum_q) + (SUM_W + 1)'(smp_a_q);
    step      = smp_a_q - prev_q;
    sweep_ext = (SWEEP_W + 1)'(sweep_q) + (SWEEP_W + 1)'(step);
    rsum_sat  = rsum_ext[SUM_W] ? '1 : rsum_ext[SUM_W-1:0];
    if (asum_ext[SUM_W] != asum_ext[SUM_W-1]) begin
      asum_sat = asum_ext[SUM_W] ? ANGLE_SUM_MIN : ANGLE_SUM_MAX;
    end else begin
      asum_sat = asum_ext[SUM_W-1:0];
    end
    if (sweep_ext[SWEEP_W] != sweep_ext[SWEEP_W-1]) begin
      sweep_sat = sweep_ext[SWEEP_W] ? SWEEP_MIN : SWEEP_MAX;
    end else begin
      sweep_sat = sweep_ext[SWEEP_W-1:0];
    end
  end

  always_comb begin
    rmin_d  = rmin_q;
    rmax_d  = rmax_q;
    rsum_d  = rsum_q;
    amin_d  = amin_q;
    amax_d  = amax_q;
    asum_d  = asum_q;
    sweep_d = sweep_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    if (apply) begin
      case (kind_q)
        KIND_CART, KIND_POLAR: begin
          if (smp_r_q < rmin_q) begin
            rmin_d = smp_r_q;
          end
          if (smp_r_q > rmax_q) begin
            rmax_d = smp_r_q;
          end
          if (smp_a_q < amin_q) begin
            amin_d = smp_a_q;
          end
          if (smp_a_q > amax_q) begin
            amax_d = smp_a_q;
          end
          rsum_d  = rsum_sat;
          asum_d  = asum_sat;
          sweep_d = sweep_sat;
          prev_d  = smp_a_q;
          if (cnt_q != '1) begin
            cnt_d = cnt_q + COUNT_BITS'(1);
          end
        end
        KIND_CLEAR: begin
          rmin_d  = '1;
          rmax_d  = '0;
          rsum_d  = '0;
          amin_d  = ANGLE_POS_MAX;
          amax_d  = ANGLE_NEG_MAX;
          asum_d  = '0;
          sweep_d = '0;
          prev_d  = '0;
          cnt_d   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      out_valid_q <= 1'b0;
      rmin_q      <= '1;
      rmax_q      <= '0;
      rsum_q      <= '0;
      amin_q      <= ANGLE_POS_MAX;
      amax_q      <= ANGLE_NEG_MAX;
      asum_q      <= '0;
      sweep_q     <= '0;
      prev_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rmin_q      <= rmin_d;
      rmax_q      <= rmax_d;
      rsum_q      <= rsum_d;
      amin_q      <= amin_d;
      amax_q      <= amax_d;
      asum_q      <= asum_d;
      sweep_q     <= sweep_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
    end
  end

  assign cnt_wide       = COUNT_MAX_BITS'(cnt_q);
  assign out_valid_o    = out_valid_q;
  assign radius_min_o   = rmin_q;
  assign radius_max_o   = rmax_q;
  assign radius_sum_o   = rsum_q;
  assign angle_min_o    = amin_q;
  assign angle_max_o    = amax_q;
  assign angle_sum_o    = asum_q;
  assign swept_angle_o  = sweep_q;
  assign sample_count_o = cnt_wide[COUNT_OUT_W-1:0];

endmodule

FILE: hdl/polar_trajectory_statistics.sv
// Running statistics over a trajectory of position samples. Each input
// transfer is a cartesian sample, a polar sample or a clear command, and each
// one yields exactly one output transfer carrying the radius and angle
// minimum, maximum and saturating sum, the unwrapped swept angle and the
// sample count. A cartesian sample passes, from its acceptance by the back
// end to its result, through squaring, the 32 steps of the shared square-root
// and CORDIC unit and the update; polar samples, clears and unused opcodes go
// straight to the update. A two-entry queue behind the input lets new
// transfers be taken while the back end is busy or a result is stalled.
// Depends on pts_pkg, pts_front, pts_queue, pts_polar and pts_back.
`timescale 1ns / 1ps

module polar_trajectory_statistics #(
  parameter int COORD_WIDTH = pts_pkg::COORD_WIDTH_DEF,
  parameter int COUNT_BITS  = pts_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] x_pos_i,
  input  logic signed [31:0] y_pos_i,
  input  logic [31:0]        radius_in_i,
  input  logic signed [31:0] angle_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        radius_min_o,
  output logic [31:0]        radius_max_o,
  output logic [55:0]        radius_sum_o,
  output logic signed [31:0] angle_min_o,
  output logic signed [31:0] angle_max_o,
  output logic signed [55:0] angle_sum_o,
  output logic signed [47:0] swept_angle_o,
  output logic [23:0]        sample_count_o
);
  import pts_pkg::*;

  logic       front_valid;
  item_t      front_item;
  logic       front_stall;
  logic       q_valid;
  item_t      q_item;
  logic       q_stall;
  polar_req_t polar_req;
  polar_rsp_t polar_rsp;

  pts_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .radius_in_i (radius_in_i),
    .angle_in_i  (angle_in_i),
    .item_valid_o(front_valid),
    .item_o      (front_item),
    .item_stall_i(front_stall)
  );

  pts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_item_i (front_item),
    .push_stall_o(front_stall),
    .pop_valid_o (q_valid),
    .pop_item_o  (q_item),
    .pop_stall_i (q_stall)
  );

  pts_polar #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_polar (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (polar_req),
    .rsp_o (polar_rsp)
  );

  pts_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_stall_o     (q_stall),
    .polar_req_o   (polar_req),
    .polar_rsp_i   (polar_rsp),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .radius_min_o  (radius_min_o),
    .radius_max_o  (radius_max_o),
    .radius_sum_o  (radius_sum_o),
    .angle_min_o   (angle_min_o),
    .angle_max_o   (angle_max_o),
    .angle_sum_o   (angle_sum_o),
    .swept_angle_o (swept_angle_o),
    .sample_count_o(sample_count_o)
  );

endmodule

FILE: bench/polar_trajectory_statistics_tb.sv
// Self-checking testbench for polar_trajectory_statistics, a directed table and then random
// trajectories, each result checked against its table entry or an in-bench model.
// Depends on pts_pkg and the polar_trajectory_statistics RTL.
`timescale 1ns / 1ps

module polar_trajectory_statistics_tb;
  import pts_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int COORD_BITS = (COORD_WIDTH_DEF > 32) ? 32 : COORD_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 60;
  localparam int REPORT_MAX = 10;

  localparam longint ASUM_HI = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint ASUM_LO = -ASUM_HI - 1;
  localparam longint SWEEP_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SWEEP_LO = -SWEEP_HI - 1;
  localparam bit [63:0] RSUM_HI = 64'h00FF_FFFF_FFFF_FFFF;
  localparam bit [63:0] COUNT_CAP = (64'd1 << COUNT_BITS_DEF) - 64'd1;

  // Arctangent steps in binary angle units, entry 0 at the top.
  localparam bit [32*32-1:0] ATAN_STEPS = {
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic [RADIUS_W-1:0]       radius_min;
    logic [RADIUS_W-1:0]       radius_max;
    logic [SUM_W-1:0]          radius_sum;
    logic signed [ANGLE_W-1:0] angle_min;
    logic signed [ANGLE_W-1:0] angle_max;
    logic signed [SUM_W-1:0]   angle_sum;
    logic signed [SWEEP_W-1:0] swept_angle;
    logic [COUNT_OUT_W-1:0]    sample_count;
  } stats_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] r;
    logic [31:0] a;
    bit          typed;
    stats_t      want;
  } row_t;

  localparam stats_t CLEARED_STATS = {32'hFFFF_FFFF, 32'd0, 56'd0, 32'h7FFF_FFFF,
                                      32'h8000_0000, 56'd0, 48'd0, 24'd0};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         opcode_i = OP_CART;
  logic signed [31:0] x_pos_i = '0;
  logic signed [31:0] y_pos_i = '0;
  logic [31:0]        radius_in_i = '0;
  logic signed [31:0] angle_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [31:0]        radius_min_o;
  logic [31:0]        radius_max_o;
  logic [55:0]        radius_sum_o;
  logic signed [31:0] angle_min_o;
  logic signed [31:0] angle_max_o;
  logic signed [55:0] angle_sum_o;
  logic signed [47:0] swept_angle_o;
  logic [23:0]        sample_count_o;

  polar_trajectory_statistics uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .radius_in_i    (radius_in_i),
    .angle_in_i     (angle_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .radius_min_o   (radius_min_o),
    .radius_max_o   (radius_max_o),
    .radius_sum_o   (radius_sum_o),
    .angle_min_o    (angle_min_o),
    .angle_max_o    (angle_max_o),
    .angle_sum_o    (angle_sum_o),
    .swept_angle_o  (swept_angle_o),
    .sample_count_o (sample_count_o)
  );

  always #2 clk_i = ~clk_i;

  // Model state of the running statistics.
  bit [31:0]          low_radius;
  bit [31:0]          high_radius;
  bit [63:0]          radius_total;
  logic signed [31:0] low_angle;
  logic signed [31:0] high_angle;
  longint             angle_total;
  longint             sweep_total;
  logic signed [31:0] last_angle;
  bit [63:0]          samples_seen;

  stats_t pending_stats[$];
  row_t   plan[$];

  bit calm = 1'b0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int unexpected = 0;
  int reported = 0;
  int results_checked = 0;
  int idle_cycles = 0;
  int n_cart = 0;
  int n_polar = 0;
  int n_clear = 0;
  int n_unused = 0;

  function automatic void clear_stats();
    low_radius = 32'hFFFF_FFFF;
    high_radius = '0;
    radius_total = '0;
    low_angle = ANGLE_POS_MAX;
    high_angle = ANGLE_NEG_MAX;
    angle_total = 0;
    sweep_total = 0;
    last_angle = '0;
    samples_seen = '0;
  endfunction

  function automatic longint widen_coord(logic [31:0] v);
    longint t;
    t = {32'b0, v};
    t = t <<< (64 - COORD_BITS);
    return t >>> (64 - COORD_BITS);
  endfunction

  function automatic bit [31:0] floor_sqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] one;
    res = '0;
    one = 64'd1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v = v - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic signed [31:0] cordic_bearing(longint x, longint y);
    longint    xs;
    longint    ys;
    bit [31:0] z;
    int        i;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (i = 0; i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEPS[(31 - i) * 32 +: 32];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEPS[(31 - i) * 32 +: 32];
      end
    end
    return z;
  endfunction

  function automatic void fold_sample(bit [31:0] r, logic signed [31:0] a);
    longint             t;
    logic signed [31:0] step;
    if (a < low_angle) low_angle = a;
    if (a > high_angle) high_angle = a;
    t = angle_total + a;
    angle_total = (t < ASUM_LO) ? ASUM_LO : ((t > ASUM_HI) ? ASUM_HI : t);
    step = a - last_angle;
    t = sweep_total + step;
    sweep_total = (t < SWEEP_LO) ? SWEEP_LO : ((t > SWEEP_HI) ? SWEEP_HI : t);
    last_angle = a;
    if (r < low_radius) low_radius = r;
    if (r > high_radius) high_radius = r;
    radius_total = radius_total + r;
    if (radius_total > RSUM_HI) radius_total = RSUM_HI;
    if (samples_seen < COUNT_CAP) samples_seen = samples_seen + 1;
  endfunction

  function automatic stats_t next_stats(row_t item);
    longint    xs;
    longint    ys;
    bit [63:0] ax;
    bit [63:0] ay;
    stats_t    s;
    case (item.op)
      OP_CART: begin
        xs = widen_coord(item.x);
        ys = widen_coord(item.y);
        ax = (xs < 0) ? -xs : xs;
        ay = (ys < 0) ? -ys : ys;
        fold_sample(floor_sqrt(ax * ax + ay * ay), cordic_bearing(xs, ys));
      end
      OP_POLAR: fold_sample(item.r, item.a);
      OP_CLEAR: clear_stats();
      default: ;
    endcase
    s.radius_min = low_radius;
    s.radius_max = high_radius;
    s.radius_sum = radius_total[SUM_W-1:0];
    s.angle_min = low_angle;
    s.angle_max = high_angle;
    s.angle_sum = angle_total[SUM_W-1:0];
    s.swept_angle = sweep_total[SWEEP_W-1:0];
    s.sample_count = samples_seen[COUNT_OUT_W-1:0];
    return s;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (reported < REPORT_MAX) begin
        reported++;
        $display("%0t: mismatch in %s: expected %h, got %h", $realtime, name, want, got);
      end
    end
  endfunction

  function automatic void check_stats(stats_t got);
    stats_t want;
    if (pending_stats.size() == 0) begin
      unexpected++;
      if (reported < REPORT_MAX) begin
        reported++;
        $display("%0t: result transfer with nothing outstanding", $realtime);
      end
    end else begin
      want = pending_stats.pop_front();
      results_checked++;
      compare_field("radius_min", want.radius_min, got.radius_min);
      compare_field("radius_max", want.radius_max, got.radius_max);
      compare_field("radius_sum", want.radius_sum, got.radius_sum);
      compare_field("angle_min", want.angle_min, got.angle_min);
      compare_field("angle_max", want.angle_max, got.angle_max);
      compare_field("angle_sum", want.angle_sum, got.angle_sum);
      compare_field("swept_angle", want.swept_angle, got.swept_angle);
      compare_field("sample_count", want.sample_count, got.sample_count);
    end
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return $urandom_range(2000) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] r, input logic [31:0] a, input bit typed,
                         input stats_t want);
    row_t item;
    item.op = op;
    item.x = x;
    item.y = y;
    item.r = r;
    item.a = a;
    item.typed = typed;
    item.want = want;
    plan.push_back(item);
  endtask

  task automatic send(input row_t item);
    stats_t predicted;
    if (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= item.op;
    x_pos_i <= item.x;
    y_pos_i <= item.y;
    radius_in_i <= item.r;
    angle_in_i <= item.a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = next_stats(item);
    pending_stats.push_back(item.typed ? item.want : predicted);
    case (item.op)
      OP_CART: n_cart++;
      OP_POLAR: n_polar++;
      OP_CLEAR: n_clear++;
      default: n_unused++;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_stats({radius_min_o, radius_max_o, radius_sum_o, angle_min_o, angle_max_o,
                     angle_sum_o, swept_angle_o, sample_count_o});
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 33);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, pending_stats.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t        item;
    bit [31:0]   track_angle;
    bit [31:0]   step;
    bit          spin;
    int          pick;
    int          n;

    track_angle = '0;
    spin = 1'b0;
    clear_stats();

    add_row(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            CLEARED_STATS);
    add_row(OP_CLEAR, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, CLEARED_STATS);
    add_row(OP_CART, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            {32'd0, 32'd0, 56'd0, 32'd0, 32'd0, 56'd0, 48'd0, 24'd1});
    add_row(OP_POLAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
            {32'd0, 32'hFFFF_FFFF, 56'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 56'h7FFF_FFFF,
             48'h7FFF_FFFF, 24'd2});
    add_row(OP_POLAR, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, '0);
    add_row(OP_CART, -32'sd5, 32'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_UNUSED, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CLEAR, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, CLEARED_STATS);
    add_row(OP_POLAR, 32'h0, 32'h0, 32'd12345, 32'h8000_0000, 1'b0, '0);
    add_row(OP_POLAR, 32'h0, 32'h0, 32'd1, 32'h7F00_0000, 1'b0, '0);
    add_row(OP_POLAR, 32'h0, 32'h0, 32'd2, 32'h8100_0000, 1'b0, '0);
    add_row(OP_CART, 32'd1, 32'd1, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CART, 32'd3, -32'sd4, 32'h0, 32'h0, 1'b0, '0);
    add_row(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            CLEARED_STATS);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (plan.size() != 0) send(plan.pop_front());

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 450 && n < 650);
      if (n == 200) hold_requests <= hold_requests + 1;
      if (n == 900) begin
        in_valid_i <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      item.x = $urandom;
      item.y = $urandom;
      item.r = $urandom;
      item.a = $urandom;
      item.typed = 1'b0;
      item.want = '0;
      pick = $urandom_range(99);
      if (pick < 4) begin
        item.op = OP_CLEAR;
        track_angle = $urandom_range(1) ? 32'h0 : $urandom;
        spin = 1'($urandom_range(1));
      end else if (pick < 7) begin
        item.op = OP_UNUSED;
      end else if (pick < 50) begin
        item.op = OP_CART;
        item.x = pick_coord();
        item.y = pick_coord();
      end else begin
        item.op = OP_POLAR;
        case ($urandom_range(9))
          0: item.r = 32'h0;
          1: item.r = 32'hFFFF_FFFF;
          2: item.r = $urandom_range(1000);
          default: ;
        endcase
        if ($urandom_range(9) < 7) begin
          step = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h1000_0000);
          track_angle = spin ? track_angle - step : track_angle + step;
          item.a = track_angle;
        end
      end
      send(item);
    end
    in_valid_i <= 1'b0;
    calm <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d transfers: %0d cartesian, %0d polar, %0d clears, %0d unused opcode.",
             n_cart + n_polar + n_clear + n_unused, n_cart, n_polar, n_clear, n_unused);
    $display("Checked %0d results, including a long output hold-off and a full drain pause.",
             results_checked);
    if (mismatches == 0 && unexpected == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/pts_pkg.sv
hdl/pts_front.sv
hdl/pts_queue.sv
hdl/pts_polar.sv
hdl/pts_back.sv
hdl/polar_trajectory_statistics.sv
bench/polar_trajectory_statistics_tb.sv
